// File: rtl/sba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated bitmap allocator package
// Shared widths, codes and small helper functions of the allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int CLASS_COUNT = 7;
    localparam int MAP_W       = 64;
    localparam int REQ_W       = 24;
    localparam int OFF_W       = 25;
    localparam int SLOT_W      = 11;
    localparam int SPAN_W      = 17;
    localparam int RES_W       = 32;

    localparam logic [SLOT_W-1:0] SLOT_MIN = 11'd8;
    localparam logic [SLOT_W-1:0] SLOT_MAX = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef logic [MAP_W-1:0] map_t;

    function automatic map_t class_mask(input logic [2:0] cls);
        logic [6:0] bits;
        begin
            bits = 7'd1 << (3'd6 - cls);
            if (cls == 3'd0)
            begin
                class_mask = '1;
            end
            else
            begin
                class_mask = (map_t'(1) << bits) - map_t'(1);
            end
        end
    endfunction

    function automatic logic [2:0] size_class(input logic [SLOT_W-1:0] m,
                                              input logic [REQ_W-1:0] size);
        logic [2:0] n;
        begin
            n = 3'd6;
            for (int k = 6; k >= 0; k--)
            begin
                if ((REQ_W'(m) << k) >= size)
                begin
                    n = 3'(k);
                end
            end
            size_class = n;
        end
    endfunction

endpackage

// File: rtl/sba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/sba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator divider
// Restoring divider, one quotient bit per cycle, shared by all requests.
// ----------------------------------------------------------------------------
module sba_div
    import sba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OFF_W-1:0]  dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [OFF_W-1:0]  quotient,
    output logic [SPAN_W-1:0] remainder
);

    localparam int CW = $clog2(OFF_W + 1);

    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] rem_next;
    logic [OFF_W-1:0]  quo_reg;
    logic [OFF_W-1:0]  quo_next;
    logic [SPAN_W-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [SPAN_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[OFF_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? SPAN_W'(trial - {1'b0, dvs_reg}) : trial[SPAN_W-1:0];
            quo_next = {quo_reg[OFF_W-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(OFF_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/segregated_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated bitmap allocator core
// Size-class slot allocator with first-fit runs of units over a header RAM
// and a free-map RAM, answering each request with an offset and a status.
// ----------------------------------------------------------------------------
// One request at a time. Every unit visited by a header walk costs one RAM
// read. Free requests and large allocates divide by the span or slot size
// in the shared divider; appending or clearing a run writes one header per
// unit.
// Reset clears the in-use count, the class cache valid bits and the output valid flag;
// the RAMs need no clearing since only written entries are ever read.
module segregated_bitmap_allocator_core
    import sba_pkg::*;
#(
    parameter int MAX_UNITS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SLOT_W-1:0] cfg_data,   // min_slot_bytes
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,    // request_bytes[23:0], free_offset[48:24]
    input  logic [0:0]        s_tuser,    // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata     // block_offset[24:0], status[26:25]
);

    localparam int UW = $clog2(MAX_UNITS);
    localparam int HW = ((UW + 2) > 4) ? (UW + 2) : 4;
    localparam logic [HW-1:0] MAXU = HW'(MAX_UNITS);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PREP    = 5'd1;
    localparam logic [4:0] S_DIVW1   = 5'd2;
    localparam logic [4:0] S_BS_CHK  = 5'd3;
    localparam logic [4:0] S_BS_EVAL = 5'd4;
    localparam logic [4:0] S_BR_CHK  = 5'd5;
    localparam logic [4:0] S_BR_EVAL = 5'd6;
    localparam logic [4:0] S_BR_END  = 5'd7;
    localparam logic [4:0] S_BS_END  = 5'd8;
    localparam logic [4:0] S_FILL    = 5'd9;
    localparam logic [4:0] S_BIG_SET = 5'd10;
    localparam logic [4:0] S_SC_CHK  = 5'd11;
    localparam logic [4:0] S_SC_EVAL = 5'd12;
    localparam logic [4:0] S_SS_CHK  = 5'd13;
    localparam logic [4:0] S_SS_EVAL = 5'd14;
    localparam logic [4:0] S_SS_NEW  = 5'd15;
    localparam logic [4:0] S_USE     = 5'd16;
    localparam logic [4:0] S_LB1     = 5'd17;
    localparam logic [4:0] S_LB2     = 5'd18;
    localparam logic [4:0] S_SM_WR   = 5'd19;
    localparam logic [4:0] S_RL_CHK  = 5'd20;
    localparam logic [4:0] S_RL_EVAL = 5'd21;
    localparam logic [4:0] S_RL_CLR  = 5'd22;
    localparam logic [4:0] S_DIVW2   = 5'd23;
    localparam logic [4:0] S_RL_WR   = 5'd24;
    localparam logic [4:0] S_MUL     = 5'd25;
    localparam logic [4:0] S_ADD     = 5'd26;
    localparam logic [4:0] S_OUT     = 5'd27;

    logic [4:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  min_slot_reg, min_slot_next;
    logic [UW:0]        uiu_reg, uiu_next;
    logic [CLASS_COUNT-1:0] cache_v_reg, cache_v_next;
    logic [UW-1:0]      cache_u_reg [CLASS_COUNT];
    logic [UW-1:0]      cache_u_next [CLASS_COUNT];
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;

    logic               op_reg, op_next;
    logic               big_reg, big_next;
    logic [REQ_W-1:0]   size_reg, size_next;
    logic [OFF_W-1:0]   addr_reg, addr_next;
    logic [SLOT_W-1:0]  m_reg, m_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [2:0]         cls_reg, cls_next;
    logic [OFF_W-1:0]   n_reg, n_next;
    logic [HW-1:0]      idx_reg, idx_next;
    logic [HW-1:0]      j_reg, j_next;
    logic [HW-1:0]      k_reg, k_next;
    logic [HW-1:0]      hdr_reg, hdr_next;
    map_t               map_reg, map_next;
    logic [5:0]         slot_reg, slot_next;
    logic [2:0]         byte_reg, byte_next;
    logic [SPAN_W-1:0]  off_reg, off_next;
    logic [1:0]         status_reg, status_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [RES_W-1:0]   prod_a_reg, prod_a_next;
    logic [23:0]        prod_b_reg, prod_b_next;

    logic               hdr_we, map_we;
    logic [UW-1:0]      ram_addr;
    logic [HW-1:0]      hdr_wdata, hdr_rdata;
    map_t               map_wdata, map_rdata;

    logic               div_start, div_done;
    logic [OFF_W-1:0]   div_a, div_q;
    logic [SPAN_W-1:0]  div_b, div_r;

    logic [SLOT_W-1:0]  m_cfg;
    logic [SPAN_W-1:0]  m64_cfg;
    logic [SPAN_W-1:0]  base_w;
    logic signed [HW-1:0] st_s;
    logic [HW-1:0]      st_len;
    logic [HW-1:0]      cls_hdr;
    logic [HW-1:0]      uiu_ext;
    logic [HW-1:0]      idx_cap;
    logic [HW-1:0]      need_w;
    logic [HW-1:0]      clr_addr;
    map_t               mask_cur;
    map_t               map_clr;
    map_t               map_set;
    logic [7:0]         byte_sel;
    logic [SPAN_W-1:0]  slot_sz;
    logic [OFF_W-1:0]   class_bits;
    logic [UW-1:0]      cu_eff;

    assign m_cfg = (min_slot_reg < SLOT_MIN) ? SLOT_MIN :
                   ((min_slot_reg > SLOT_MAX) ? SLOT_MAX : min_slot_reg);
    assign m64_cfg    = SPAN_W'(m_cfg) << 6;
    assign base_w     = (SPAN_W'(m_reg) << 6) + SPAN_W'(8);
    assign st_s       = $signed(hdr_rdata);
    assign st_len     = HW'(-st_s);
    assign cls_hdr    = HW'(cls_reg) + HW'(1);
    assign uiu_ext    = HW'(uiu_reg);
    assign idx_cap    = (idx_reg > uiu_ext) ? uiu_ext : idx_reg;
    assign need_w     = HW'(n_reg) - (uiu_ext - idx_cap);
    assign clr_addr   = idx_reg + k_reg;
    assign mask_cur   = class_mask(cls_reg);
    assign map_clr    = map_reg & ~(map_t'(1) << slot_reg);
    assign map_set    = map_reg | (map_t'(1) << slot_reg);
    assign byte_sel   = map_reg[8*byte_reg +: 8];
    assign slot_sz    = SPAN_W'(m_reg) << cls_reg;
    assign class_bits = OFF_W'(1) << (3'd6 - cls_reg);
    assign cu_eff     = cache_v_reg[cls_reg] ? cache_u_reg[cls_reg] : idx_reg[UW-1:0];

    sba_ram #(.WIDTH(HW), .DEPTH(MAX_UNITS)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .addr  (ram_addr),
        .wdata (hdr_wdata),
        .rdata (hdr_rdata)
    );

    sba_ram #(.WIDTH(MAP_W), .DEPTH(MAX_UNITS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .addr  (ram_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    sba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        min_slot_next  = min_slot_reg;
        uiu_next       = uiu_reg;
        cache_v_next   = cache_v_reg;
        cache_u_next   = cache_u_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        op_next        = op_reg;
        big_next       = big_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        m_next         = m_reg;
        span_next      = span_reg;
        cls_next       = cls_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        hdr_next       = hdr_reg;
        map_next       = map_reg;
        slot_next      = slot_reg;
        byte_next      = byte_reg;
        off_next       = off_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        hdr_we         = 1'b0;
        map_we         = 1'b0;
        ram_addr       = idx_reg[UW-1:0];
        hdr_wdata      = '0;
        map_wdata      = map_reg;
        div_start      = 1'b0;
        div_a          = addr_reg;
        div_b          = span_reg;

        if (cfg_valid)
        begin
            min_slot_next = cfg_data;
        end
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser[0];
                    size_next   = s_tdata[23:0];
                    addr_next   = s_tdata[48:24];
                    m_next      = m_cfg;
                    span_next   = m64_cfg + SPAN_W'(12);
                    cls_next    = size_class(m_cfg, s_tdata[23:0]);
                    big_next    = (s_tuser[0] == OP_ALLOC) &&
                                  (s_tdata[23:0] > REQ_W'(m64_cfg));
                    status_next = ST_OK;
                    res_next    = '0;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                if (op_reg == OP_FREE)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW1;
                end
                else if (big_reg)
                begin
                    if (size_reg >= REQ_W'(base_w))
                    begin
                        div_start  = 1'b1;
                        div_a      = OFF_W'(size_reg - REQ_W'(base_w));
                        state_next = S_DIVW1;
                    end
                    else
                    begin
                        n_next     = OFF_W'(2);
                        idx_next   = '0;
                        state_next = S_BS_CHK;
                    end
                end
                else if (cache_v_reg[cls_reg] && (HW'(cache_u_reg[cls_reg]) < uiu_ext))
                begin
                    idx_next   = HW'(cache_u_reg[cls_reg]);
                    state_next = S_SC_CHK;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_SS_CHK;
                end
            end
            S_DIVW1:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_FREE)
                    begin
                        if (div_q >= OFF_W'(uiu_reg))
                        begin
                            status_next = ST_BADFREE;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            idx_next   = HW'(div_q);
                            off_next   = div_r;
                            state_next = S_RL_CHK;
                        end
                    end
                    else
                    begin
                        n_next     = div_q + OFF_W'(2);
                        idx_next   = '0;
                        state_next = S_BS_CHK;
                    end
                end
            end
            S_BS_CHK:
            begin
                state_next = (idx_reg >= uiu_ext) ? S_BS_END : S_BS_EVAL;
            end
            S_BS_EVAL:
            begin
                if (st_s == '0)
                begin
                    j_next     = idx_reg + HW'(1);
                    state_next = S_BR_CHK;
                end
                else if (st_s < 0)
                begin
                    idx_next   = idx_reg + st_len;
                    state_next = S_BS_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + HW'(1);
                    state_next = S_BS_CHK;
                end
            end
            S_BR_CHK:
            begin
                ram_addr = j_reg[UW-1:0];
                if ((j_reg < uiu_ext) && (OFF_W'(j_reg - idx_reg) < n_reg))
                begin
                    state_next = S_BR_EVAL;
                end
                else
                begin
                    state_next = S_BR_END;
                end
            end
            S_BR_EVAL:
            begin
                if (st_s == '0)
                begin
                    j_next     = j_reg + HW'(1);
                    state_next = S_BR_CHK;
                end
                else
                begin
                    state_next = S_BR_END;
                end
            end
            S_BR_END:
            begin
                if (OFF_W'(j_reg - idx_reg) >= n_reg)
                begin
                    state_next = S_BIG_SET;
                end
                else if (j_reg >= uiu_ext)
                begin
                    state_next = S_BS_END;
                end
                else
                begin
                    idx_next   = j_reg;
                    state_next = S_BS_CHK;
                end
            end
            S_BS_END:
            begin
                if ((n_reg > OFF_W'(MAX_UNITS)) || (need_w > (MAXU - uiu_ext)))
                begin
                    status_next = ST_NOMEM;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next   = idx_cap;
                    k_next     = uiu_ext;
                    j_next     = uiu_ext + need_w;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_addr = k_reg[UW-1:0];
                if (k_reg < j_reg)
                begin
                    hdr_we = 1'b1;
                    k_next = k_reg + HW'(1);
                end
                else
                begin
                    uiu_next   = (UW+1)'(j_reg);
                    state_next = S_BIG_SET;
                end
            end
            S_BIG_SET:
            begin
                hdr_we     = 1'b1;
                hdr_wdata  = -HW'(n_reg);
                slot_next  = '0;
                state_next = S_MUL;
            end
            S_SC_CHK:
            begin
                state_next = S_SC_EVAL;
            end
            S_SC_EVAL:
            begin
                if ((hdr_rdata == cls_hdr) && (map_rdata != '0))
                begin
                    hdr_next   = hdr_rdata;
                    map_next   = map_rdata;
                    state_next = S_USE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_SS_CHK;
                end
            end
            S_SS_CHK:
            begin
                state_next = (idx_reg >= uiu_ext) ? S_SS_NEW : S_SS_EVAL;
            end
            S_SS_EVAL:
            begin
                if ((st_s == '0) || ((hdr_rdata == cls_hdr) && (map_rdata != '0)))
                begin
                    hdr_next              = hdr_rdata;
                    map_next              = map_rdata;
                    cache_v_next[cls_reg] = 1'b1;
                    cache_u_next[cls_reg] = idx_reg[UW-1:0];
                    state_next            = S_USE;
                end
                else if (st_s > 0)
                begin
                    idx_next   = idx_reg + HW'(1);
                    state_next = S_SS_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + st_len;
                    state_next = S_SS_CHK;
                end
            end
            S_SS_NEW:
            begin
                if (uiu_ext >= MAXU)
                begin
                    status_next = ST_NOMEM;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next              = uiu_ext;
                    uiu_next              = uiu_reg + (UW+1)'(1);
                    hdr_next              = '0;
                    cache_v_next[cls_reg] = 1'b1;
                    cache_u_next[cls_reg] = uiu_reg[UW-1:0];
                    state_next            = S_USE;
                end
            end
            S_USE:
            begin
                if (hdr_reg == '0)
                begin
                    map_next = mask_cur;
                end
                state_next = S_LB1;
            end
            S_LB1:
            begin
                byte_next = 3'd7;
                for (int b = 7; b >= 0; b--)
                begin
                    if (map_reg[8*b +: 8] != 8'd0)
                    begin
                        byte_next = 3'(b);
                    end
                end
                state_next = S_LB2;
            end
            S_LB2:
            begin
                slot_next = {byte_reg, 3'd7};
                for (int i = 7; i >= 0; i--)
                begin
                    if (byte_sel[i])
                    begin
                        slot_next = {byte_reg, 3'(i)};
                    end
                end
                state_next = S_SM_WR;
            end
            S_SM_WR:
            begin
                hdr_we    = 1'b1;
                hdr_wdata = cls_hdr;
                map_we    = 1'b1;
                map_wdata = map_clr;
                if (map_clr == '0)
                begin
                    cache_v_next[cls_reg] = 1'b0;
                end
                state_next = S_MUL;
            end
            S_RL_CHK:
            begin
                state_next = S_RL_EVAL;
            end
            S_RL_EVAL:
            begin
                if (st_s == '0)
                begin
                    status_next = ST_BADFREE;
                    state_next  = S_OUT;
                end
                else if (st_s < 0)
                begin
                    if (off_reg != SPAN_W'(4))
                    begin
                        status_next = ST_BADFREE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        k_next     = '0;
                        j_next     = st_len;
                        state_next = S_RL_CLR;
                    end
                end
                else if ((st_s > HW'(7)) || (off_reg < SPAN_W'(12)))
                begin
                    status_next = ST_BADFREE;
                    state_next  = S_OUT;
                end
                else
                begin
                    cls_next   = 3'(hdr_rdata - HW'(1));
                    map_next   = map_rdata;
                    div_start  = 1'b1;
                    div_a      = OFF_W'(off_reg - SPAN_W'(12));
                    div_b      = SPAN_W'(m_reg) << 3'(hdr_rdata - HW'(1));
                    state_next = S_DIVW2;
                end
            end
            S_RL_CLR:
            begin
                ram_addr = clr_addr[UW-1:0];
                if ((k_reg < j_reg) && (clr_addr < MAXU))
                begin
                    hdr_we = 1'b1;
                    k_next = k_reg + HW'(1);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIVW2:
            begin
                if (div_done)
                begin
                    if ((div_q >= class_bits) || (div_r != '0) || map_reg[div_q[5:0]])
                    begin
                        status_next = ST_BADFREE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        slot_next  = div_q[5:0];
                        state_next = S_RL_WR;
                    end
                end
            end
            S_RL_WR:
            begin
                map_we    = 1'b1;
                map_wdata = map_set;
                if (!cache_v_reg[cls_reg])
                begin
                    cache_v_next[cls_reg] = 1'b1;
                    cache_u_next[cls_reg] = idx_reg[UW-1:0];
                end
                if ((cu_eff != idx_reg[UW-1:0]) && (map_set == mask_cur))
                begin
                    hdr_we = 1'b1;
                end
                state_next = S_OUT;
            end
            S_MUL:
            begin
                prod_a_next = RES_W'(idx_reg[UW-1:0]) * RES_W'(span_reg);
                prod_b_next = 24'(slot_reg) * 24'(slot_sz);
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                if (big_reg)
                begin
                    res_next = prod_a_reg + RES_W'(4);
                end
                else
                begin
                    res_next = prod_a_reg + RES_W'(12) + RES_W'(prod_b_reg);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0, status_reg, res_reg[OFF_W-1:0]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_slot_reg  <= 11'd128;
            uiu_reg       <= '0;
            cache_v_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_slot_reg  <= min_slot_next;
            uiu_reg       <= uiu_next;
            cache_v_reg   <= cache_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_u_reg  <= cache_u_next;
        out_data_reg <= out_data_next;
        op_reg       <= op_next;
        big_reg      <= big_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        m_reg        <= m_next;
        span_reg     <= span_next;
        cls_reg      <= cls_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        hdr_reg      <= hdr_next;
        map_reg      <= map_next;
        slot_reg     <= slot_next;
        byte_reg     <= byte_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
    end

    a_uiu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        HW'(uiu_reg) <= MAXU)
        else $error("units in use exceed the pool");

    a_uiu_grows: assert property (@(posedge clk) disable iff (!rst_n)
        uiu_reg >= $past(uiu_reg))
        else $error("units in use decreased");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIVW1) || (state_reg == S_DIVW2)))
        else $error("divider finished outside a wait state");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[26:25] != 2'd3))
        else $error("undefined status code on output");

endmodule
